// ===== hw/rtl/stms_pkg.sv =====
`timescale 1ns / 1ps
package stms_pkg;

  localparam int ID_W   = 32;
  localparam int SZ_W   = 48;
  localparam int FAC_W  = 16;
  localparam int WID_W  = 7;
  localparam int CFG_AW = 2;
  localparam int CFG_DW = 16;

  // Most ids one run may return.
  localparam logic [WID_W-1:0] RESULT_CAP = 7'd64;

  typedef enum logic [CFG_AW-1:0] {
    REG_LOW_FACTOR  = 2'd0,
    REG_HIGH_FACTOR = 2'd1,
    REG_MIN_WIDTH   = 2'd2,
    REG_MAX_WIDTH   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic            valid;
    logic [SZ_W-1:0] size;
    logic [ID_W-1:0] id;
  } entry_t;

  typedef struct packed {
    logic ins;  // sorted insert of the broadcast entry
    logic rot;  // shift towards the head, head wraps to the tail
    logic clr;  // drop every entry
  } cell_ctl_t;

endpackage

// ===== hw/rtl/stms_cell.sv =====
`timescale 1ns / 1ps
module stms_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  stms_pkg::cell_ctl_t ctl,
  input  stms_pkg::entry_t    new_ent,
  input  stms_pkg::entry_t    prev_ent,
  input  logic                prev_lt,
  input  stms_pkg::entry_t    next_ent,
  output stms_pkg::entry_t    ent,
  output logic                lt
);

  stms_pkg::entry_t ent_r;
  stms_pkg::entry_t ent_nxt;

  // New entry sorts ahead of this one (an empty cell is always behind).
  assign lt = !ent_r.valid || (new_ent.size < ent_r.size) ||
              ((new_ent.size == ent_r.size) && (new_ent.id < ent_r.id));
  assign ent = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    if (ctl.clr) begin
      ent_nxt.valid = 1'b0;
    end else if (ctl.ins && lt) begin
      ent_nxt = prev_lt ? prev_ent : new_ent;
    end else if (ctl.rot) begin
      ent_nxt = next_ent;
    end
  end

  // Only the valid bit is reset; the payload is don't-care while empty.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.valid <= 1'b0;
    end else begin
      ent_r.valid <= ent_nxt.valid;
    end
    ent_r.size <= ent_nxt.size;
    ent_r.id   <= ent_nxt.id;
  end

endmodule

// ===== hw/rtl/size_tiered_merge_selector_top.sv =====
`timescale 1ns / 1ps
// Loading: one table transaction per cycle, sorted on entry by a chain of cells.
// Selection after the final item: a scan of the sorted chain that holds once at each loaded
// table after the first, a closing step for the last bucket, a full rotation to gather the
// chosen bucket if one qualified, then one result per free cycle.
// Input is stalled from the final item until the last result is registered.
// Reset (rst_n, synchronous, active low) empties both chains, resets control and config.
module size_tiered_merge_selector_top #(
  parameter int MAX_TABLES = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [stms_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic [stms_pkg::CFG_DW-1:0]  cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [stms_pkg::ID_W-1:0]    in_table_id,
  input  logic [stms_pkg::SZ_W-1:0]    in_size_bytes,
  input  logic                         in_final_item,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [stms_pkg::ID_W-1:0]    out_chosen_id,
  output logic                         out_found,
  output logic                         out_end_of_run,
  output logic                         out_overflowed
);

  localparam int CW   = $clog2(MAX_TABLES + 1);  // counts up to MAX_TABLES
  localparam int PW   = $clog2(MAX_TABLES);      // positions in the chain
  localparam int SUMW = stms_pkg::SZ_W + CW;     // bucket size sum
  localparam int PLW  = stms_pkg::SZ_W + CW;     // size * count
  localparam int CMPW = SUMW + stms_pkg::FAC_W;  // factor * sum
  localparam int WCW  = CW + stms_pkg::WID_W;

  typedef enum logic [5:0] {
    S_LOAD  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_DEC   = 6'b000100,
    S_CLOSE = 6'b001000,
    S_PICK  = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [stms_pkg::FAC_W-1:0] low_r, high_r;
  logic [stms_pkg::WID_W-1:0] min_w_r, max_w_r;

  // load state
  logic [CW-1:0] load_cnt_r, load_cnt_nxt;
  logic          ovf_r, ovf_nxt;

  // scan state
  logic [PW-1:0]   pos_r, pos_nxt;
  logic [PW-1:0]   bstart_r, bstart_nxt;
  logic [CW-1:0]   bcnt_r, bcnt_nxt;
  logic [SUMW-1:0] bsum_r, bsum_nxt;
  logic [stms_pkg::ID_W-1:0] bmin_r, bmin_nxt;
  logic            have_r, have_nxt;
  logic [PW-1:0]   best_start_r, best_start_nxt;
  logic [CW-1:0]   best_cnt_r, best_cnt_nxt;
  logic [stms_pkg::ID_W-1:0] best_min_r, best_min_nxt;
  logic [PLW-1:0]  prod_l_r;
  logic [CMPW-1:0] prod_lo_r, prod_hi_r;

  // emit state
  logic [CW-1:0] cap_r, cap_nxt;
  logic [CW-1:0] k_r, k_nxt;

  // output register
  logic                      out_valid_r, out_valid_nxt;
  logic [stms_pkg::ID_W-1:0] out_id_r, out_id_nxt;
  logic                      out_found_r, out_found_nxt;
  logic                      out_end_r, out_end_nxt;
  logic                      out_ovf_r, out_ovf_nxt;

  // chains
  stms_pkg::cell_ctl_t main_ctl, pick_ctl;
  stms_pkg::entry_t    main_new, pick_new;
  stms_pkg::entry_t    main_ent [MAX_TABLES];
  stms_pkg::entry_t    pick_ent [MAX_TABLES];
  logic                main_lt  [MAX_TABLES];
  logic                pick_lt  [MAX_TABLES];
  stms_pkg::entry_t    head;

  logic in_acc, out_free, pos_last, fits, qual, in_range, run_end;
  logic [CMPW-1:0] lhs;
  logic [CW:0]     pos_off;
  logic [stms_pkg::WID_W-1:0] mw;
  logic [WCW-1:0]  capx;

  assign head     = main_ent[0];
  assign in_stall = (state_r != S_LOAD);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign pos_last = (pos_r == PW'(MAX_TABLES - 1));

  assign main_new = '{valid: 1'b1, size: in_size_bytes, id: in_table_id};
  // Pick chain sorts on id alone: size forced to zero.
  assign pick_new = '{valid: 1'b1, size: '0, id: head.id};

  genvar gi;
  generate
    for (gi = 0; gi < MAX_TABLES; gi++) begin : g_chain
      localparam int NX = (gi + 1) % MAX_TABLES;
      stms_cell u_main (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (main_ctl),
        .new_ent  (main_new),
        .prev_ent ((gi == 0) ? stms_pkg::entry_t'('0) : main_ent[(gi == 0) ? 0 : gi - 1]),
        .prev_lt  ((gi == 0) ? 1'b0 : main_lt[(gi == 0) ? 0 : gi - 1]),
        .next_ent (main_ent[NX]),
        .ent      (main_ent[gi]),
        .lt       (main_lt[gi])
      );
      stms_cell u_pick (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (pick_ctl),
        .new_ent  (pick_new),
        .prev_ent ((gi == 0) ? stms_pkg::entry_t'('0) : pick_ent[(gi == 0) ? 0 : gi - 1]),
        .prev_lt  ((gi == 0) ? 1'b0 : pick_lt[(gi == 0) ? 0 : gi - 1]),
        .next_ent (pick_ent[NX]),
        .ent      (pick_ent[gi]),
        .lt       (pick_lt[gi])
      );
    end
  endgenerate

  // Exact bucket test: size*count*256 between low*sum and high*sum.
  assign lhs  = CMPW'({prod_l_r, 8'b0});
  assign fits = (lhs >= prod_lo_r) && (lhs <= prod_hi_r);

  // Closing bucket qualifies and beats the best one so far.
  assign qual = (bcnt_r != '0) &&
                (WCW'(bcnt_r) >= WCW'(min_w_r)) &&
                (!have_r || (bmin_r < best_min_r));

  assign pos_off  = (CW + 1)'(pos_r) - (CW + 1)'(best_start_r);
  assign in_range = (pos_r >= best_start_r) && (pos_off < (CW + 1)'(best_cnt_r));

  // Result count: max_width with zero as one, capped at the result limit and bucket size.
  assign mw   = (max_w_r == '0) ? stms_pkg::WID_W'(1) :
                (max_w_r > stms_pkg::RESULT_CAP) ? stms_pkg::RESULT_CAP : max_w_r;
  assign capx = (WCW'(mw) < WCW'(best_cnt_r)) ? WCW'(mw) : WCW'(best_cnt_r);

  assign run_end = ((CW + 1)'(k_r) + (CW + 1)'(1)) == (CW + 1)'(cap_r);

  always_comb begin
    state_nxt      = state_r;
    load_cnt_nxt   = load_cnt_r;
    ovf_nxt        = ovf_r;
    pos_nxt        = pos_r;
    bstart_nxt     = bstart_r;
    bcnt_nxt       = bcnt_r;
    bsum_nxt       = bsum_r;
    bmin_nxt       = bmin_r;
    have_nxt       = have_r;
    best_start_nxt = best_start_r;
    best_cnt_nxt   = best_cnt_r;
    best_min_nxt   = best_min_r;
    cap_nxt        = cap_r;
    k_nxt          = k_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_id_nxt     = out_id_r;
    out_found_nxt  = out_found_r;
    out_end_nxt    = out_end_r;
    out_ovf_nxt    = out_ovf_r;
    main_ctl       = '0;
    pick_ctl       = '0;

    case (state_r)
      S_LOAD: begin
        if (in_acc) begin
          // Store while there is room; drop and flag otherwise.
          if (load_cnt_r != CW'(MAX_TABLES)) begin
            main_ctl.ins = 1'b1;
            load_cnt_nxt = load_cnt_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_final_item) begin
            state_nxt = S_SCAN;
            pos_nxt   = '0;
            bcnt_nxt  = '0;
            have_nxt  = 1'b0;
          end
        end
      end
      S_SCAN: begin
        if (head.valid && (bcnt_r != '0)) begin
          // Hold the head while the products settle.
          state_nxt = S_DEC;
        end else begin
          if (head.valid) begin
            bstart_nxt = pos_r;
            bcnt_nxt   = CW'(1);
            bsum_nxt   = SUMW'(head.size);
            bmin_nxt   = head.id;
          end
          main_ctl.rot = 1'b1;
          pos_nxt      = pos_r + PW'(1);
          if (pos_last) begin
            state_nxt = S_CLOSE;
          end
        end
      end
      S_DEC: begin
        if (fits) begin
          bcnt_nxt = bcnt_r + CW'(1);
          bsum_nxt = bsum_r + SUMW'(head.size);
          if (head.id < bmin_r) begin
            bmin_nxt = head.id;
          end
        end else begin
          if (qual) begin
            have_nxt       = 1'b1;
            best_start_nxt = bstart_r;
            best_cnt_nxt   = bcnt_r;
            best_min_nxt   = bmin_r;
          end
          bstart_nxt = pos_r;
          bcnt_nxt   = CW'(1);
          bsum_nxt   = SUMW'(head.size);
          bmin_nxt   = head.id;
        end
        main_ctl.rot = 1'b1;
        pos_nxt      = pos_r + PW'(1);
        state_nxt    = pos_last ? S_CLOSE : S_SCAN;
      end
      S_CLOSE: begin
        if (qual) begin
          have_nxt       = 1'b1;
          best_start_nxt = bstart_r;
          best_cnt_nxt   = bcnt_r;
          best_min_nxt   = bmin_r;
        end
        pos_nxt   = '0;
        state_nxt = (qual || have_r) ? S_PICK : S_EMIT;
      end
      S_PICK: begin
        // Full rotation: gather the chosen bucket's ids into the pick chain.
        main_ctl.rot = 1'b1;
        pick_ctl.ins = in_range;
        pos_nxt      = pos_r + PW'(1);
        if (pos_last) begin
          state_nxt = S_EMIT;
          k_nxt     = '0;
          cap_nxt   = capx[CW-1:0];
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_ovf_nxt   = ovf_r;
          if (have_r) begin
            out_id_nxt    = pick_ent[0].id;
            out_found_nxt = 1'b1;
            out_end_nxt   = run_end;
            pick_ctl.rot  = 1'b1;
            k_nxt         = k_r + CW'(1);
          end else begin
            out_id_nxt    = '0;
            out_found_nxt = 1'b0;
            out_end_nxt   = 1'b1;
          end
          if (!have_r || run_end) begin
            // Run over: clear the load state for the next set.
            main_ctl.clr = 1'b1;
            pick_ctl.clr = 1'b1;
            load_cnt_nxt = '0;
            ovf_nxt      = 1'b0;
            state_nxt    = S_LOAD;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r   <= stms_pkg::FAC_W'(128);
      high_r  <= stms_pkg::FAC_W'(384);
      min_w_r <= stms_pkg::WID_W'(4);
      max_w_r <= stms_pkg::WID_W'(32);
    end else if (cfg_we) begin
      case (stms_pkg::cfg_reg_t'(cfg_addr))
        stms_pkg::REG_LOW_FACTOR:  low_r   <= cfg_wdata;
        stms_pkg::REG_HIGH_FACTOR: high_r  <= cfg_wdata;
        stms_pkg::REG_MIN_WIDTH:   min_w_r <= cfg_wdata[stms_pkg::WID_W-1:0];
        stms_pkg::REG_MAX_WIDTH:   max_w_r <= cfg_wdata[stms_pkg::WID_W-1:0];
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      load_cnt_r  <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      have_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      load_cnt_r  <= load_cnt_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      have_r      <= have_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    bstart_r     <= bstart_nxt;
    bcnt_r       <= bcnt_nxt;
    bsum_r       <= bsum_nxt;
    bmin_r       <= bmin_nxt;
    best_start_r <= best_start_nxt;
    best_cnt_r   <= best_cnt_nxt;
    best_min_r   <= best_min_nxt;
    cap_r        <= cap_nxt;
    k_r          <= k_nxt;
    out_id_r     <= out_id_nxt;
    out_found_r  <= out_found_nxt;
    out_end_r    <= out_end_nxt;
    out_ovf_r    <= out_ovf_nxt;
    // products of the head against the open bucket
    prod_l_r     <= PLW'(head.size) * PLW'(bcnt_r);
    prod_lo_r    <= CMPW'(low_r) * CMPW'(bsum_r);
    prod_hi_r    <= CMPW'(high_r) * CMPW'(bsum_r);
  end

  assign out_valid      = out_valid_r;
  assign out_chosen_id  = out_id_r;
  assign out_found      = out_found_r;
  assign out_end_of_run = out_end_r;
  assign out_overflowed = out_ovf_r;

  a_load_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    load_cnt_r <= CW'(MAX_TABLES))
    else $error("load count beyond capacity");

  a_not_found_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_found_r |-> out_end_r && (out_id_r == '0))
    else $error("not-found result malformed");

  a_final_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_final_item |=> in_stall)
    else $error("input taken after final item");

endmodule
